>>> src/tlca_pkg.sv
// Shared types and command codes for the tree LCA binary lifting unit.
// Used by tlca_ctrl and tree_lca_binary_lifting_unit; no dependencies.
package tlca_pkg;

   localparam logic [1:0] CMD_SET   = 2'd0;
   localparam logic [1:0] CMD_BUILD = 2'd1;
   localparam logic [1:0] CMD_QUERY = 2'd2;

   localparam logic [9:0] NODE_COUNT_RESET = 10'd1023;

   typedef struct packed {
      logic [1:0] cmd;
      logic [9:0] node_a;
      logic [9:0] node_b;
      logic [9:0] depth_value;
   } req_type;

   typedef struct packed {
      logic        valid;
      logic [9:0]  common_ancestor;
      logic [10:0] path_length;
      logic [1:0]  cmd_done;
   } rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_SET_WR,
      ST_B_RD1,
      ST_B_RD2,
      ST_B_WR,
      ST_Q_RDA,
      ST_Q_RDB,
      ST_Q_ORDER,
      ST_Q_LIFT,
      ST_Q_LIFT_WB,
      ST_Q_EQ,
      ST_Q_JA,
      ST_Q_JB,
      ST_Q_JC,
      ST_Q_PAR,
      ST_Q_PAR_WB,
      ST_Q_DL,
      ST_Q_DL_WB
   } state_type;

endpackage

>>> src/tree_lca_binary_lifting_unit.sv
// One transaction at a time; the next is taken in the cycle its predecessor's result is
// strobed. The receiver cannot stall. A build covers nodes 1 to min(node_count,
// MAX_NODES-1) and writes nothing when that is 0; a query skips the jump search when
// the lifted nodes meet.
// Synchronous reset clears the sequencer and sets node_count to 1023; RAMs are not cleared.
module tree_lca_binary_lifting_unit #(
   parameter int MAX_NODES   = 1024,
   parameter int LIFT_LEVELS = 10
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_cmd,
   input  logic [9:0]  req_node_a,
   input  logic [9:0]  req_node_b,
   input  logic [9:0]  req_depth_value,
   output logic        rsp_valid,
   output logic [9:0]  rsp_common_ancestor,
   output logic [10:0] rsp_path_length,
   output logic [1:0]  rsp_cmd_done,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [9:0]  csr_node_count
);

   localparam int NODE_AW   = $clog2(MAX_NODES);
   localparam int TBL_DEPTH = LIFT_LEVELS * (2 ** NODE_AW);
   localparam int TBL_AW    = $clog2(TBL_DEPTH);
   localparam int DEP_DEPTH = 2 ** NODE_AW;

   tlca_pkg::req_type req;
   tlca_pkg::rsp_type rsp;
   logic [9:0]        node_count_ff, node_count_in;

   logic              tbl_we;
   logic [TBL_AW-1:0] tbl_waddr;
   logic [9:0]        tbl_wdata;
   logic [TBL_AW-1:0] tbl_raddr;
   logic [9:0]        tbl_rdata;
   logic               dep_we;
   logic [NODE_AW-1:0] dep_waddr;
   logic [9:0]         dep_wdata;
   logic [NODE_AW-1:0] dep_raddr;
   logic [9:0]         dep_rdata;

   assign csr_ready     = 1'b1;
   assign node_count_in = (csr_valid && csr_ready) ? csr_node_count : node_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= tlca_pkg::NODE_COUNT_RESET;
      end else begin
         node_count_ff <= node_count_in;
      end
   end

   assign req.cmd         = req_cmd;
   assign req.node_a      = req_node_a;
   assign req.node_b      = req_node_b;
   assign req.depth_value = req_depth_value;

   tlca_ctrl #(
      .MAX_NODES   (MAX_NODES),
      .LIFT_LEVELS (LIFT_LEVELS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req        (req),
      .node_count (node_count_ff),
      .rsp        (rsp),
      .tbl_we     (tbl_we),
      .tbl_waddr  (tbl_waddr),
      .tbl_wdata  (tbl_wdata),
      .tbl_raddr  (tbl_raddr),
      .tbl_rdata  (tbl_rdata),
      .dep_we     (dep_we),
      .dep_waddr  (dep_waddr),
      .dep_wdata  (dep_wdata),
      .dep_raddr  (dep_raddr),
      .dep_rdata  (dep_rdata)
   );

   // Ancestor table: entry {level, node} holds the node's ancestor 2^level steps up.
   tlca_ram #(
      .WIDTH (10),
      .DEPTH (TBL_DEPTH)
   ) u_tbl_ram (
      .clock (clock),
      .we    (tbl_we),
      .waddr (tbl_waddr),
      .wdata (tbl_wdata),
      .raddr (tbl_raddr),
      .rdata (tbl_rdata)
   );

   tlca_ram #(
      .WIDTH (10),
      .DEPTH (DEP_DEPTH)
   ) u_dep_ram (
      .clock (clock),
      .we    (dep_we),
      .waddr (dep_waddr),
      .wdata (dep_wdata),
      .raddr (dep_raddr),
      .rdata (dep_rdata)
   );

   assign rsp_valid           = rsp.valid;
   assign rsp_common_ancestor = rsp.common_ancestor;
   assign rsp_path_length     = rsp.path_length;
   assign rsp_cmd_done        = rsp.cmd_done;

endmodule

>>> src/tlca_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies; contents are not initialized.
module tlca_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> src/tlca_ctrl.sv
// Command sequencer for set, build and query over the ancestor and depth RAMs.
// Depends on tlca_pkg; drives the two tlca_ram instances held by the top level.
module tlca_ctrl #(
   parameter int MAX_NODES   = 1024,
   parameter int LIFT_LEVELS = 10
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  tlca_pkg::req_type     req,
   input  logic [9:0]            node_count,
   output tlca_pkg::rsp_type     rsp,
   output logic                  tbl_we,
   output logic [$clog2(LIFT_LEVELS*(2**$clog2(MAX_NODES)))-1:0] tbl_waddr,
   output logic [9:0]            tbl_wdata,
   output logic [$clog2(LIFT_LEVELS*(2**$clog2(MAX_NODES)))-1:0] tbl_raddr,
   input  logic [9:0]            tbl_rdata,
   output logic                  dep_we,
   output logic [$clog2(MAX_NODES)-1:0] dep_waddr,
   output logic [9:0]            dep_wdata,
   output logic [$clog2(MAX_NODES)-1:0] dep_raddr,
   input  logic [9:0]            dep_rdata
);

   localparam int NODE_AW = $clog2(MAX_NODES);
   localparam int LVL_W   = (LIFT_LEVELS > 1) ? $clog2(LIFT_LEVELS) : 1;
   localparam int TBL_AW  = $clog2(LIFT_LEVELS * (2 ** NODE_AW));
   localparam logic [LVL_W-1:0] LVL_TOP   = LVL_W'(LIFT_LEVELS - 1);
   localparam logic [LVL_W-1:0] LVL_BUILD = LVL_W'(LIFT_LEVELS - 2);

   function automatic logic in_range(input logic [9:0] v);
      return (32'(v) < MAX_NODES);
   endfunction

   function automatic logic [9:0] clip(input logic [9:0] v);
      return in_range(v) ? v : 10'd0;
   endfunction

   function automatic logic [TBL_AW-1:0] tbl_addr(input logic [LVL_W-1:0] lvl,
                                                  input logic [NODE_AW-1:0] idx);
      return TBL_AW'({lvl, idx});
   endfunction

   tlca_pkg::state_type state_ff, state_in;
   tlca_pkg::rsp_type   rsp_ff, rsp_in;
   logic [1:0]          cmd_ff, cmd_in;
   logic [9:0]          a_ff, a_in;
   logic [9:0]          b_ff, b_in;
   logic [9:0]          dv_ff, dv_in;
   logic [9:0]          da_ff, da_in;
   logic [9:0]          db_ff, db_in;
   logic [9:0]          diff_ff, diff_in;
   logic [9:0]          pa_ff, pa_in;
   logic [9:0]          lca_ff, lca_in;
   logic [LVL_W-1:0]    lvl_ff, lvl_in;
   logic [NODE_AW-1:0]  n_ff, n_in;
   logic [NODE_AW-1:0]  last_ff, last_in;
   logic                tz_ff, tz_in;
   logic                dz_ff, dz_in;

   logic [9:0]          t_val;
   logic [9:0]          d_val;
   logic [9:0]          diff_shift;
   logic [NODE_AW-1:0]  build_last;
   logic signed [12:0]  len_calc;
   logic                accept;

   // Node 0 and out-of-range nodes are never stored; their reads are forced to zero.
   assign t_val = tz_ff ? 10'd0 : clip(tbl_rdata);
   assign d_val = dz_ff ? 10'd0 : dep_rdata;
   assign diff_shift = diff_ff >> 1;
   assign build_last = (32'(node_count) > MAX_NODES - 1) ? NODE_AW'(MAX_NODES - 1)
                                                         : NODE_AW'(node_count);
   assign len_calc = $signed({3'b000, da_ff}) + $signed({3'b000, db_ff})
                   - $signed({2'b00, d_val, 1'b0});
   assign accept = start && (state_ff == tlca_pkg::ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= tlca_pkg::ST_IDLE;
         rsp_ff.valid <= 1'b0;
         lvl_ff    <= '0;
         n_ff      <= NODE_AW'(1);
         last_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         rsp_ff    <= rsp_in;
         lvl_ff    <= lvl_in;
         n_ff      <= n_in;
         last_ff   <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      dv_ff   <= dv_in;
      da_ff   <= da_in;
      db_ff   <= db_in;
      diff_ff <= diff_in;
      pa_ff   <= pa_in;
      lca_ff  <= lca_in;
      tz_ff   <= tz_in;
      dz_ff   <= dz_in;
   end

   always_comb begin
      state_in  = state_ff;
      rsp_in    = rsp_ff;
      rsp_in.valid = 1'b0;
      cmd_in    = cmd_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      dv_in     = dv_ff;
      da_in     = da_ff;
      db_in     = db_ff;
      diff_in   = diff_ff;
      pa_in     = pa_ff;
      lca_in    = lca_ff;
      lvl_in    = lvl_ff;
      n_in      = n_ff;
      last_in   = last_ff;
      tz_in     = 1'b1;
      dz_in     = 1'b1;
      tbl_we    = 1'b0;
      tbl_waddr = '0;
      tbl_wdata = '0;
      tbl_raddr = '0;
      dep_we    = 1'b0;
      dep_waddr = '0;
      dep_wdata = '0;
      dep_raddr = '0;

      unique case (state_ff)
         tlca_pkg::ST_IDLE: begin
            if (accept) begin
               cmd_in  = req.cmd;
               a_in    = clip(req.node_a);
               b_in    = (req.cmd == tlca_pkg::CMD_QUERY) ? clip(req.node_b) : req.node_b;
               dv_in   = req.depth_value;
               lvl_in  = '0;
               n_in    = NODE_AW'(1);
               last_in = build_last;
               rsp_in.common_ancestor = '0;
               rsp_in.path_length     = '0;
               rsp_in.cmd_done        = req.cmd;
               unique case (req.cmd)
                  tlca_pkg::CMD_SET: begin
                     state_in = tlca_pkg::ST_SET_WR;
                  end
                  tlca_pkg::CMD_BUILD: begin
                     if (LIFT_LEVELS < 2 || build_last == '0) begin
                        rsp_in.valid = 1'b1;
                     end else begin
                        state_in = tlca_pkg::ST_B_RD1;
                     end
                  end
                  tlca_pkg::CMD_QUERY: begin
                     state_in = tlca_pkg::ST_Q_RDA;
                  end
                  default: begin
                     rsp_in.valid = 1'b1;
                  end
               endcase
            end
         end

         tlca_pkg::ST_SET_WR: begin
            // a_ff is zero when the node is null or out of range; such a set is dropped.
            tbl_we    = (a_ff != 10'd0);
            tbl_waddr = tbl_addr('0, NODE_AW'(a_ff));
            tbl_wdata = b_ff;
            dep_we    = (a_ff != 10'd0);
            dep_waddr = NODE_AW'(a_ff);
            dep_wdata = dv_ff;
            rsp_in.valid = 1'b1;
            state_in  = tlca_pkg::ST_IDLE;
         end

         // Build reads level k twice and writes level k+1, one node at a time, so a
         // write never meets a read of the same entry in flight.
         tlca_pkg::ST_B_RD1: begin
            tbl_raddr = tbl_addr(lvl_ff, n_ff);
            tz_in     = 1'b0;
            state_in  = tlca_pkg::ST_B_RD2;
         end

         tlca_pkg::ST_B_RD2: begin
            tbl_raddr = tbl_addr(lvl_ff, NODE_AW'(t_val));
            tz_in     = (t_val == 10'd0);
            state_in  = tlca_pkg::ST_B_WR;
         end

         tlca_pkg::ST_B_WR: begin
            tbl_we    = 1'b1;
            tbl_waddr = tbl_addr(lvl_ff + LVL_W'(1), n_ff);
            tbl_wdata = t_val;
            state_in  = tlca_pkg::ST_B_RD1;
            if (n_ff == last_ff) begin
               n_in = NODE_AW'(1);
               if (lvl_ff == LVL_BUILD) begin
                  rsp_in.valid = 1'b1;
                  state_in     = tlca_pkg::ST_IDLE;
               end else begin
                  lvl_in = lvl_ff + LVL_W'(1);
               end
            end else begin
               n_in = n_ff + NODE_AW'(1);
            end
         end

         tlca_pkg::ST_Q_RDA: begin
            dep_raddr = NODE_AW'(a_ff);
            dz_in     = (a_ff == 10'd0);
            state_in  = tlca_pkg::ST_Q_RDB;
         end

         tlca_pkg::ST_Q_RDB: begin
            da_in     = d_val;
            dep_raddr = NODE_AW'(b_ff);
            dz_in     = (b_ff == 10'd0);
            state_in  = tlca_pkg::ST_Q_ORDER;
         end

         // After this state a_ff is the shallower node and b_ff the deeper one.
         tlca_pkg::ST_Q_ORDER: begin
            if (da_ff > d_val) begin
               a_in    = b_ff;
               b_in    = a_ff;
               da_in   = d_val;
               db_in   = da_ff;
               diff_in = da_ff - d_val;
            end else begin
               db_in   = d_val;
               diff_in = d_val - da_ff;
            end
            lvl_in   = '0;
            state_in = tlca_pkg::ST_Q_LIFT;
         end

         tlca_pkg::ST_Q_LIFT: begin
            if (diff_ff == 10'd0) begin
               state_in = tlca_pkg::ST_Q_EQ;
            end else if (diff_ff[0]) begin
               tbl_raddr = tbl_addr(lvl_ff, NODE_AW'(b_ff));
               tz_in     = (b_ff == 10'd0);
               state_in  = tlca_pkg::ST_Q_LIFT_WB;
            end else begin
               diff_in = diff_shift;
               if (lvl_ff == LVL_TOP || diff_shift == 10'd0) begin
                  state_in = tlca_pkg::ST_Q_EQ;
               end else begin
                  lvl_in = lvl_ff + LVL_W'(1);
               end
            end
         end

         tlca_pkg::ST_Q_LIFT_WB: begin
            b_in    = t_val;
            diff_in = diff_shift;
            if (lvl_ff == LVL_TOP || diff_shift == 10'd0) begin
               state_in = tlca_pkg::ST_Q_EQ;
            end else begin
               lvl_in   = lvl_ff + LVL_W'(1);
               state_in = tlca_pkg::ST_Q_LIFT;
            end
         end

         tlca_pkg::ST_Q_EQ: begin
            if (a_ff == b_ff) begin
               lca_in   = a_ff;
               state_in = tlca_pkg::ST_Q_DL;
            end else begin
               lvl_in   = LVL_TOP;
               state_in = tlca_pkg::ST_Q_JA;
            end
         end

         tlca_pkg::ST_Q_JA: begin
            tbl_raddr = tbl_addr(lvl_ff, NODE_AW'(a_ff));
            tz_in     = (a_ff == 10'd0);
            state_in  = tlca_pkg::ST_Q_JB;
         end

         tlca_pkg::ST_Q_JB: begin
            pa_in     = t_val;
            tbl_raddr = tbl_addr(lvl_ff, NODE_AW'(b_ff));
            tz_in     = (b_ff == 10'd0);
            state_in  = tlca_pkg::ST_Q_JC;
         end

         tlca_pkg::ST_Q_JC: begin
            if (pa_ff != t_val) begin
               a_in = pa_ff;
               b_in = t_val;
            end
            if (lvl_ff == '0) begin
               state_in = tlca_pkg::ST_Q_PAR;
            end else begin
               lvl_in   = lvl_ff - LVL_W'(1);
               state_in = tlca_pkg::ST_Q_JA;
            end
         end

         tlca_pkg::ST_Q_PAR: begin
            tbl_raddr = tbl_addr('0, NODE_AW'(a_ff));
            tz_in     = (a_ff == 10'd0);
            state_in  = tlca_pkg::ST_Q_PAR_WB;
         end

         tlca_pkg::ST_Q_PAR_WB: begin
            lca_in   = t_val;
            state_in = tlca_pkg::ST_Q_DL;
         end

         tlca_pkg::ST_Q_DL: begin
            dep_raddr = NODE_AW'(lca_ff);
            dz_in     = (lca_ff == 10'd0);
            state_in  = tlca_pkg::ST_Q_DL_WB;
         end

         tlca_pkg::ST_Q_DL_WB: begin
            rsp_in.valid           = 1'b1;
            rsp_in.common_ancestor = lca_ff;
            rsp_in.path_length     = (len_calc < 0) ? 11'd0 : len_calc[10:0];
            rsp_in.cmd_done        = cmd_ff;
            state_in               = tlca_pkg::ST_IDLE;
         end

         default: begin
            state_in = tlca_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != tlca_pkg::ST_IDLE);
   assign rsp  = rsp_ff;

   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_ff.valid |-> (state_ff == tlca_pkg::ST_IDLE))
      else $error("result strobe while a command is still running");

   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      accept |=> (busy || rsp_ff.valid))
      else $error("accepted transaction neither running nor answered");

   a_tbl_write_src: assert property (@(posedge clock) disable iff (reset)
      tbl_we |-> (state_ff == tlca_pkg::ST_SET_WR || state_ff == tlca_pkg::ST_B_WR))
      else $error("ancestor table written outside set or build");

   a_level_range: assert property (@(posedge clock) disable iff (reset)
      busy |-> (32'(lvl_ff) < LIFT_LEVELS))
      else $error("lift level out of range");

   a_build_node: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tlca_pkg::ST_B_RD1) |-> (n_ff != '0 && n_ff <= last_ff))
      else $error("build node counter out of range");

endmodule

>>> tb/tree_lca_binary_lifting_unit_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for tree_lca_binary_lifting_unit: node updates, table builds and
// LCA queries are checked against an in-bench predictor. Depends on tlca_pkg and the unit RTL.
module tree_lca_binary_lifting_unit_test;

   localparam int NODES         = 1024;
   localparam int LEVELS        = 10;
   localparam int RANDOM_ITEMS  = 250;
   localparam int SETTLE_CYCLES = 100;
   localparam int PRINT_CAP     = 200;
   localparam logic [1:0] CMD_SPARE = 2'd3;

   typedef enum logic [1:0] {OP_REQUEST, OP_CSR_WRITE, OP_DRAIN} op_kind_type;

   typedef struct {
      op_kind_type       kind;
      tlca_pkg::req_type req;
      logic [9:0]        span;
      int                gap;
   } backlog_entry_type;

   typedef struct {
      logic [9:0]  ancestor;
      logic [10:0] length;
      logic [1:0]  cmd;
   } answer_type;

   logic        clock           = 1'b0;
   logic        reset           = 1'b1;
   logic        start           = 1'b0;
   logic        busy;
   logic [1:0]  req_cmd         = tlca_pkg::CMD_SET;
   logic [9:0]  req_node_a      = '0;
   logic [9:0]  req_node_b      = '0;
   logic [9:0]  req_depth_value = '0;
   logic        rsp_valid;
   logic [9:0]  rsp_common_ancestor;
   logic [10:0] rsp_path_length;
   logic [1:0]  rsp_cmd_done;
   logic        csr_valid       = 1'b0;
   logic        csr_ready;
   logic [9:0]  csr_node_count  = '0;

   backlog_entry_type backlog[$];
   answer_type        answers_due[$];
   backlog_entry_type cur_entry;
   bit             have_entry  = 1'b0;
   int             gap_left    = 0;
   bit             req_fired   = 1'b0;
   bit             csr_fired   = 1'b0;
   int             error_count = 0;
   longint         cycle_count = 0;
   longint         cycle_limit = 0;

   // Predictor copy of the tree and the build span.
   logic [9:0] model_up [LEVELS][NODES];
   logic [9:0] model_depth [NODES];
   logic [9:0] model_span = tlca_pkg::NODE_COUNT_RESET;

   // Stimulus-side view of depths and span, used to make consistent node updates.
   logic [9:0] plan_depth [NODES];
   logic [9:0] plan_span  = tlca_pkg::NODE_COUNT_RESET;
   int         burst_left = 0;

   tree_lca_binary_lifting_unit dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_cmd             (req_cmd),
      .req_node_a          (req_node_a),
      .req_node_b          (req_node_b),
      .req_depth_value     (req_depth_value),
      .rsp_valid           (rsp_valid),
      .rsp_common_ancestor (rsp_common_ancestor),
      .rsp_path_length     (rsp_path_length),
      .rsp_cmd_done        (rsp_cmd_done),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_node_count      (csr_node_count)
   );

   always #6 clock = ~clock;

   task automatic report_error(string msg);
      if (error_count < PRINT_CAP) begin
         $display("ERROR: %s", msg);
      end
      error_count++;
   endtask

   function automatic answer_type predict_lca_step(tlca_pkg::req_type r);
      answer_type ans;
      logic [9:0] a, b, t, pa, pb, diff;
      int         k, n, da, db, dl, edge_total;
      ans.ancestor = '0;
      ans.length   = '0;
      ans.cmd      = r.cmd;
      case (r.cmd)
         tlca_pkg::CMD_SET: begin
            // The null node keeps parent 0 and depth 0.
            if (r.node_a != '0) begin
               model_up[0][r.node_a] = r.node_b;
               model_depth[r.node_a] = r.depth_value;
            end
         end
         tlca_pkg::CMD_BUILD: begin
            for (k = 0; k < LEVELS - 1; k++) begin
               for (n = 1; n <= model_span; n++) begin
                  model_up[k + 1][n] = model_up[k][model_up[k][n]];
               end
            end
         end
         tlca_pkg::CMD_QUERY: begin
            a = r.node_a;
            b = r.node_b;
            if (model_depth[a] > model_depth[b]) begin
               t = a;
               a = b;
               b = t;
            end
            diff = model_depth[b] - model_depth[a];
            for (k = 0; k < LEVELS; k++) begin
               if (diff[k]) b = model_up[k][b];
            end
            if (a != b) begin
               for (k = LEVELS - 1; k >= 0; k--) begin
                  pa = model_up[k][a];
                  pb = model_up[k][b];
                  if (pa != pb) begin
                     a = pa;
                     b = pb;
                  end
               end
               a = model_up[0][a];
            end
            ans.ancestor = a;
            da = model_depth[r.node_a];
            db = model_depth[r.node_b];
            dl = model_depth[a];
            edge_total = da + db - 2 * dl;
            // Inconsistent depths can drive the distance negative; it floors at zero.
            ans.length = (edge_total < 0) ? 11'd0 : edge_total[10:0];
         end
         default: begin
         end
      endcase
      return ans;
   endfunction

   function automatic int draw_gap();
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      if ($urandom_range(0, 39) == 0) begin
         burst_left = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, 7);
   endfunction

   task automatic push_req(logic [1:0] cmd, logic [9:0] a, logic [9:0] b, logic [9:0] d);
      backlog_entry_type e;
      e.kind            = OP_REQUEST;
      e.req.cmd         = cmd;
      e.req.node_a      = a;
      e.req.node_b      = b;
      e.req.depth_value = d;
      e.span            = plan_span;
      e.gap             = draw_gap();
      backlog.insert(backlog.size(), e);
      case (cmd)
         tlca_pkg::CMD_SET: begin
            if (a != '0) plan_depth[a] = d;
            cycle_limit += 16;
         end
         tlca_pkg::CMD_BUILD: cycle_limit += 16 + 3 * (LEVELS - 1) * plan_span;
         tlca_pkg::CMD_QUERY: cycle_limit += 16 + 12 + 5 * LEVELS;
         default:   cycle_limit += 16;
      endcase
   endtask

   task automatic push_tree_set(logic [9:0] n, logic [9:0] p);
      push_req(tlca_pkg::CMD_SET, n, p, plan_depth[p] + 10'd1);
   endtask

   task automatic push_drain();
      backlog_entry_type e;
      e.kind = OP_DRAIN;
      e.req  = '0;
      e.span = plan_span;
      e.gap  = 0;
      backlog.insert(backlog.size(), e);
      cycle_limit += 4;
   endtask

   // The span register is only written once every outstanding transaction has answered.
   task automatic push_csr(logic [9:0] span);
      backlog_entry_type e;
      push_drain();
      e.kind    = OP_CSR_WRITE;
      e.req     = '0;
      e.span    = span;
      e.gap     = draw_gap();
      plan_span = span;
      backlog.insert(backlog.size(), e);
      cycle_limit += 16;
   endtask

   task automatic push_random_query(int lo, int hi);
      push_req(tlca_pkg::CMD_QUERY, 10'($urandom_range(lo, hi)), 10'($urandom_range(lo, hi)),
               10'($urandom_range(0, NODES - 1)));
   endtask

   // Monitor: checks strobed results and records accepted transactions.
   always @(posedge clock) begin
      answer_type        want;
      tlca_pkg::req_type seen;
      if (reset) begin
         req_fired = 1'b0;
         csr_fired = 1'b0;
      end else begin
         if (rsp_valid) begin
            if (answers_due.size() == 0) begin
               report_error($sformatf("result with nothing outstanding: cmd_done %0d",
                                      rsp_cmd_done));
            end else begin
               want = answers_due.pop_front();
               if (rsp_common_ancestor !== want.ancestor || rsp_path_length !== want.length ||
                   rsp_cmd_done !== want.cmd) begin
                  report_error($sformatf(
                     "got anc %0d len %0d cmd %0d, expected anc %0d len %0d cmd %0d",
                     rsp_common_ancestor, rsp_path_length, rsp_cmd_done,
                     want.ancestor, want.length, want.cmd));
               end
            end
         end
         req_fired = start && !busy;
         if (req_fired) begin
            seen.cmd         = req_cmd;
            seen.node_a      = req_node_a;
            seen.node_b      = req_node_b;
            seen.depth_value = req_depth_value;
            answers_due.insert(answers_due.size(), predict_lca_step(seen));
         end
         csr_fired = csr_valid && csr_ready;
         if (csr_fired) model_span = csr_node_count;
      end
   end

   // Driver: works through the backlog one entry at a time on falling edges.
   always @(negedge clock) begin
      bit next_start;
      bit next_csr;
      next_start = start;
      next_csr   = csr_valid;
      if (!reset) begin
         if (start && req_fired) begin
            next_start = 1'b0;
            have_entry = 1'b0;
         end
         if (csr_valid && csr_fired) begin
            next_csr   = 1'b0;
            have_entry = 1'b0;
         end
         if (!have_entry && backlog.size() != 0) begin
            cur_entry  = backlog.pop_front();
            have_entry = 1'b1;
            gap_left   = cur_entry.gap;
         end
         if (have_entry && !next_start && !next_csr) begin
            if (gap_left > 0) begin
               gap_left--;
            end else begin
               case (cur_entry.kind)
                  OP_REQUEST: begin
                     req_cmd         <= cur_entry.req.cmd;
                     req_node_a      <= cur_entry.req.node_a;
                     req_node_b      <= cur_entry.req.node_b;
                     req_depth_value <= cur_entry.req.depth_value;
                     next_start = 1'b1;
                  end
                  OP_CSR_WRITE: begin
                     if (answers_due.size() == 0 && !busy) begin
                        csr_node_count <= cur_entry.span;
                        next_csr = 1'b1;
                     end
                  end
                  default: begin
                     if (answers_due.size() == 0) have_entry = 1'b0;
                  end
               endcase
            end
         end
      end
      start     <= next_start;
      csr_valid <= next_csr;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > cycle_limit) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      int n, k, kind, items, full_builds;
      for (n = 0; n < NODES; n++) begin
         for (k = 0; k < LEVELS; k++) begin
            model_up[k][n] = '0;
         end
         model_depth[n] = '0;
         plan_depth[n]  = '0;
      end

      // Every node gets a parent and depth, and the reset span builds the whole table, so no
      // later transaction can touch an entry that was never written. Mostly long chains.
      push_req(tlca_pkg::CMD_SET, 1, 0, 0);
      for (n = 2; n < NODES; n++) begin
         if ($urandom_range(0, 3) == 0) push_tree_set(10'(n), 10'($urandom_range(1, n - 1)));
         else push_tree_set(10'(n), 10'(n - 1));
      end
      push_req(tlca_pkg::CMD_BUILD, 10'($urandom_range(0, NODES - 1)),
               10'($urandom_range(0, NODES - 1)), 10'($urandom_range(0, NODES - 1)));

      // Directed cases: extreme nodes, null node, unused command, inconsistent depths,
      // empty span and full span.
      push_req(tlca_pkg::CMD_QUERY, NODES - 1, 1, 10'h3FF);
      push_req(tlca_pkg::CMD_QUERY, 1, 1, 10'h000);
      push_req(tlca_pkg::CMD_QUERY, 0, 0, 10'h000);
      push_req(tlca_pkg::CMD_QUERY, 0, NODES - 1, 10'h155);
      push_req(tlca_pkg::CMD_QUERY, 512, NODES - 1, 10'h2AA);
      push_req(tlca_pkg::CMD_QUERY, 700, 300, 10'h000);
      push_req(CMD_SPARE, 10'h3FF, 10'h3FF, 10'h3FF);
      push_req(tlca_pkg::CMD_SET, 0, 10'h3FF, 10'h3FF);
      push_req(tlca_pkg::CMD_QUERY, 0, 5, 10'h000);
      push_req(tlca_pkg::CMD_SET, NODES - 1, 1, 10'h3FF);
      push_req(tlca_pkg::CMD_QUERY, NODES - 1, 1, 10'h000);
      push_req(tlca_pkg::CMD_QUERY, 2, NODES - 1, 10'h000);
      // A root deeper than its children makes the distance formula go negative.
      push_csr(3);
      push_req(tlca_pkg::CMD_SET, 1, 0, 1000);
      push_req(tlca_pkg::CMD_SET, 2, 1, 1);
      push_req(tlca_pkg::CMD_SET, 3, 1, 1);
      push_req(tlca_pkg::CMD_BUILD, 0, 0, 0);
      push_req(tlca_pkg::CMD_QUERY, 2, 3, 0);
      push_csr(0);
      push_req(tlca_pkg::CMD_SET, 1, 0, 0);
      push_req(tlca_pkg::CMD_BUILD, 10'h3FF, 10'h3FF, 10'h3FF);
      push_req(tlca_pkg::CMD_QUERY, 3, 2, 0);
      push_csr(NODES - 1);
      push_req(tlca_pkg::CMD_BUILD, 0, 0, 0);
      push_req(tlca_pkg::CMD_QUERY, NODES - 1, 3, 0);

      items       = 0;
      full_builds = 0;
      while (items < RANDOM_ITEMS) begin
         kind = $urandom_range(0, 99);
         if (kind < 60) begin
            if (kind < 4) push_random_query(0, NODES - 1);
            else push_random_query(1, NODES - 1);
            items++;
         end else if (kind < 85) begin
            n = $urandom_range(2, NODES - 1);
            if (kind < 81) push_tree_set(10'(n), 10'($urandom_range(1, n - 1)));
            else push_req(tlca_pkg::CMD_SET, 10'(n), 10'($urandom_range(0, NODES - 1)),
                          10'($urandom_range(0, NODES - 1)));
            items++;
         end else if (kind < 90) begin
            // Rebuilds mostly cover a small prefix of the nodes to keep the run short.
            if (full_builds < 1 && $urandom_range(0, 29) == 0) begin
               push_csr(NODES - 1);
               full_builds++;
            end else if ($urandom_range(0, 9) == 0) begin
               push_csr(0);
            end else begin
               push_csr(10'($urandom_range(1, 64)));
            end
            push_req(tlca_pkg::CMD_BUILD, 10'($urandom_range(0, NODES - 1)),
                     10'($urandom_range(0, NODES - 1)), 10'($urandom_range(0, NODES - 1)));
            items++;
         end else if (kind < 95) begin
            for (k = 0; k < 4; k++) begin
               push_random_query(1, 64);
            end
            items += 4;
         end else if (kind < 97) begin
            push_req(tlca_pkg::CMD_SET, 0, 10'($urandom_range(0, NODES - 1)),
                     10'($urandom_range(0, NODES - 1)));
         end else if (kind < 98) begin
            push_req(CMD_SPARE, 10'($urandom_range(0, NODES - 1)),
                     10'($urandom_range(0, NODES - 1)), 10'($urandom_range(0, NODES - 1)));
         end else begin
            push_drain();
         end
      end
      cycle_limit = 4 * cycle_limit + 20000;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (backlog.size() != 0 || have_entry || answers_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (answers_due.size() != 0) begin
         report_error($sformatf("%0d results never arrived", answers_due.size()));
      end
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

>>> files.f
src/tlca_pkg.sv
src/tlca_ram.sv
src/tlca_ctrl.sv
src/tree_lca_binary_lifting_unit.sv
tb/tree_lca_binary_lifting_unit_test.sv
